>>> design/ansyn_pkg.sv
`default_nettype none
// Shared types, constants and elaboration-time table builders for the additive note synth.
// Used by the channel interfaces and by additive_note_synth_core.
package ansyn_pkg;

	localparam int MAX_HARM_DEF   = 32;
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int SAMPLE_W_DEF   = 16;

	localparam int CFG_W     = 25;
	localparam int CFG_IDX_W = 3;
	localparam int PHASE_W   = 32;
	localparam int IDX_W     = 24;
	localparam int ENV_W     = 25;
	localparam int GAIN_W    = 16;
	localparam int COUNT_W   = 6;
	localparam int MUL_B_W   = 28;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FUND_GAIN,
		REG_BALANCE,
		REG_COUNT,
		REG_OUT_GAIN,
		REG_ATTACK_LEN,
		REG_NOTE_LEN,
		REG_ATTACK_STEP,
		REG_DECAY_STEP
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PO,
		ST_PE,
		ST_NO,
		ST_NE,
		ST_FUND,
		ST_HA,
		ST_HB,
		ST_ENV,
		ST_MENV,
		ST_TRUNC,
		ST_MGAIN,
		ST_OUT
	} state_t;

	localparam logic [GAIN_W-1:0]  Q15_ONE         = 16'd32768;
	localparam logic [ENV_W-1:0]   ENV_MAX         = '1;
	localparam logic [GAIN_W-1:0]  FUND_GAIN_RST   = 16'd32768;
	localparam logic [GAIN_W-1:0]  BALANCE_RST     = 16'd16384;
	localparam logic [COUNT_W-1:0] COUNT_RST       = 6'd1;
	localparam logic [GAIN_W-1:0]  OUT_GAIN_RST    = 16'd32768;
	localparam logic [IDX_W-1:0]   ATTACK_LEN_RST  = '0;
	localparam logic [IDX_W-1:0]   NOTE_LEN_RST    = 24'd1;
	localparam logic [ENV_W-1:0]   ATTACK_STEP_RST = '0;
	localparam logic [ENV_W-1:0]   DECAY_STEP_RST  = '0;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint C1 = 64'sd1686629713;
	localparam longint C3 = -64'sd693598669;
	localparam longint C5 = 64'sd85569304;
	localparam longint C7 = -64'sd5026995;
	localparam longint C9 = 64'sd172271;

	function automatic longint mul_q30(longint a, longint b);
		return (a * b) / Q30_ONE;
	endfunction

	// Q1.15 sine of table entry k for a table of 2**aw entries.
	function automatic logic signed [15:0] sine_entry(int k, int aw);
		longint ang;
		longint x;
		longint x2;
		longint p;
		longint y;
		longint v;
		logic [1:0] quad;
		ang = longint'(k) << (PHASE_W - aw);
		quad = 2'((ang >> 30) & 64'sd3);
		x = ang & 64'sh3FFF_FFFF;
		if (quad[0])
			x = Q30_ONE - x;
		x2 = mul_q30(x, x);
		p = C9;
		p = C7 + mul_q30(p, x2);
		p = C5 + mul_q30(p, x2);
		p = C3 + mul_q30(p, x2);
		p = C1 + mul_q30(p, x2);
		y = mul_q30(p, x);
		if (y < 0)
			y = 0;
		v = (y * 64'sd32767 + (Q30_ONE / 2)) / Q30_ONE;
		if (v > 64'sd32767)
			v = 64'sd32767;
		if (quad[1])
			v = -v;
		return 16'(v);
	endfunction

	// ceil(2**k / d) by shift-subtract long division.
	function automatic logic [MUL_B_W-2:0] recip_ceil(int d, int k);
		longint unsigned n;
		longint unsigned rem;
		longint unsigned q;
		longint unsigned dd;
		n = (64'd1 << k) + 64'(d) - 64'd1;
		rem = '0;
		q = '0;
		dd = 64'(d);
		if (d == 0)
			return '0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | 64'(n[b]);
			q = q << 1;
			if (rem >= dd) begin
				rem = rem - dd;
				q = q | 64'd1;
			end
		end
		return (MUL_B_W-1)'(q);
	endfunction

endpackage
`default_nettype wire

>>> design/ansyn_tick_if.sv
`default_nettype none
// Input channel of the additive note synth: one sample tick per request.
// Carries valid, ready, start_req and phase_step.
interface ansyn_tick_if;
	logic                            valid;
	logic                            ready;
	logic                            start_req;
	logic [ansyn_pkg::PHASE_W-1:0]   phase_step;

	modport source (output valid, output start_req, output phase_step, input ready);
	modport sink (input valid, input start_req, input phase_step, output ready);
endinterface
`default_nettype wire

>>> design/ansyn_smp_if.sv
`default_nettype none
// Output channel of the additive note synth: one audio sample per request.
// Carries valid, ready, sample, active and last; width from SAMPLE_WIDTH.
interface ansyn_smp_if #(
	parameter int SAMPLE_WIDTH = ansyn_pkg::SAMPLE_W_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           active;
	logic                           last;

	modport source (output valid, output sample, output active, output last, input ready);
	modport sink (input valid, input sample, input active, input last, output ready);
endinterface
`default_nettype wire

>>> design/additive_note_synth_core.sv
`default_nettype none
// Top level of the additive note synth: sequencer, shared multiplier, sine ROM and output register.
// Depends on ansyn_pkg, ansyn_tick_if and ansyn_smp_if.
//
// One voice of additive synthesis with a linear attack/decay envelope. Each tick request yields
// exactly one sample request; a tick with start_req set begins a note on that same tick. A tick
// while no note sounds goes straight to the output step and returns a zero sample. A sounding
// tick takes one pair of steps per harmonic past the fundamental, up to count, where count is the
// clamped harmonic count: a single registered multiplier does all products and each harmonic
// term needs two of them (gain from a reciprocal table, then gain times sine). The sine comes
// from a SINE_TABLE_DEPTH-entry ROM with registered read. A finished sample waits in the output
// register, and the block holds in its last step only if that register is still full.
module additive_note_synth_core #(
	parameter int MAX_HARMONICS    = ansyn_pkg::MAX_HARM_DEF,
	parameter int SINE_TABLE_DEPTH = ansyn_pkg::SINE_DEPTH_DEF,
	parameter int SAMPLE_WIDTH     = ansyn_pkg::SAMPLE_W_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ansyn_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [ansyn_pkg::CFG_W-1:0]     cfg_data,
	ansyn_tick_if.sink                           tick,
	ansyn_smp_if.source                          audio
);

	localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
	localparam int CNT_W   = $clog2(MAX_HARMONICS + 1);
	localparam int RK      = 14 + 2 * $clog2(MAX_HARMONICS);
	localparam int ACC_W   = 32 + $clog2(MAX_HARMONICS);
	localparam int MA_W    = ACC_W + 2;
	localparam int MB_W    = ansyn_pkg::MUL_B_W;
	localparam int P_W     = MA_W + MB_W;
	localparam int N_W     = 31 + CNT_W;
	localparam int M_W     = N_W - 16;
	localparam int V_W     = ACC_W + 1;
	localparam int W_W     = ACC_W - 14;
	localparam int UP      = (SAMPLE_WIDTH >= 16) ? SAMPLE_WIDTH - 16 : 0;
	localparam int DN      = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
	localparam int SC_W    = W_W + UP;
	localparam int PW      = ansyn_pkg::PHASE_W;
	localparam int IW      = ansyn_pkg::IDX_W;
	localparam int EW      = ansyn_pkg::ENV_W;
	localparam int GW      = ansyn_pkg::GAIN_W;

	localparam logic [W_W-1:0]         DN_MASK  = W_W'((1 << DN) - 1);
	localparam logic signed [SC_W-1:0] SMAX_EXT = SC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SC_W-1:0] SMIN_EXT = ~SMAX_EXT;

	typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];
	typedef logic [MB_W-2:0] recip_tab_t [MAX_HARMONICS+1];

	function automatic sine_rom_t build_sine();
		sine_rom_t r;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++)
			r[k] = ansyn_pkg::sine_entry(k, SINE_AW);
		return r;
	endfunction

	function automatic recip_tab_t build_recip();
		recip_tab_t r;
		for (int d = 0; d <= MAX_HARMONICS; d++)
			r[d] = ansyn_pkg::recip_ceil(d, RK);
		return r;
	endfunction

	localparam sine_rom_t  SINE_ROM  = build_sine();
	localparam recip_tab_t RECIP_TAB = build_recip();

	ansyn_pkg::state_t state_q, state_d;

	logic [GW-1:0]                   fg_q, bal_q, og_q;
	logic [ansyn_pkg::COUNT_W-1:0]   hc_q;
	logic [IW-1:0]                   alen_q, nlen_q;
	logic [EW-1:0]                   astep_q, dstep_q;

	logic [IW-1:0]                   idx_q;
	logic [EW-1:0]                   env_q;
	logic [PW-1:0]                   phase_q, step_q;
	logic                            act_q;

	logic [CNT_W-1:0]                cnt_q, cnt_d, i_q, i_inc;
	logic                            zero_q, zero_d;
	logic [PW-1:0]                   hph_q;
	logic signed [15:0]              rom_q;
	logic signed [P_W-1:0]           prod_q, prod_d;
	logic signed [ACC_W-1:0]         acc_q, acc_add;
	logic [30:0]                     po_q, pe_q;
	logic [N_W-1:0]                  nodd_q, neven_q, nodd_dec, neven_dec, nsel;
	logic [M_W-1:0]                  m_val;
	logic signed [V_W-1:0]           v_q, v_d;

	logic                            mul_en;
	logic signed [MA_W-1:0]          mul_a;
	logic signed [MB_W-1:0]          mul_b;
	logic                            accept, slot_free, out_load, out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  sample_q, res_sample;
	logic                            active_q, last_q, res_last;

	logic [GW-1:0]                   fg_sat, bal_sat, og_sat, fgap, bal_inv;
	logic [IW-1:0]                   len_eff;
	logic [EW:0]                     env_sum;
	logic [EW-1:0]                   env_next;
	logic [P_W-1:0]                  t24, t30;
	logic signed [W_W-1:0]           w_d, w_rnd, w_dn;
	logic signed [SC_W-1:0]          w_sc;

	assign fg_sat  = (fg_q > ansyn_pkg::Q15_ONE) ? ansyn_pkg::Q15_ONE : fg_q;
	assign bal_sat = (bal_q > ansyn_pkg::Q15_ONE) ? ansyn_pkg::Q15_ONE : bal_q;
	assign og_sat  = (og_q > ansyn_pkg::Q15_ONE) ? ansyn_pkg::Q15_ONE : og_q;
	assign fgap    = ansyn_pkg::Q15_ONE - fg_sat;
	assign bal_inv = ansyn_pkg::Q15_ONE - bal_sat;
	assign len_eff = (nlen_q == '0) ? IW'(1) : nlen_q;

	assign accept    = tick.valid && tick.ready;
	assign slot_free = !out_valid_q || audio.ready;
	assign zero_d    = !(tick.start_req || act_q);
	assign i_inc     = i_q + CNT_W'(1);

	always_comb begin
		if (hc_q == '0)
			cnt_d = CNT_W'(1);
		else if (int'(hc_q) > MAX_HARMONICS)
			cnt_d = CNT_W'(MAX_HARMONICS);
		else
			cnt_d = CNT_W'(hc_q);
	end

	assign nodd_dec  = nodd_q - N_W'(po_q);
	assign neven_dec = neven_q - N_W'(pe_q);
	assign nsel      = i_q[0] ? nodd_dec : neven_dec;
	assign m_val     = nsel[N_W-1:16];

	assign acc_add = acc_q + $signed(prod_q[ACC_W-1:0]);

	assign env_sum  = {1'b0, env_q} + {1'b0, astep_q};
	always_comb begin
		if (idx_q < alen_q)
			env_next = env_sum[EW] ? ansyn_pkg::ENV_MAX : env_sum[EW-1:0];
		else if (env_q > dstep_q)
			env_next = env_q - dstep_q;
		else
			env_next = '0;
	end

	assign prod_d = P_W'(mul_a) * P_W'(mul_b);

	assign t24 = prod_q + (prod_q[P_W-1] ? P_W'(24'hFF_FFFF) : '0);
	assign v_d = t24[24 +: V_W];
	assign t30 = prod_q + (prod_q[P_W-1] ? P_W'(30'h3FFF_FFFF) : '0);
	assign w_d = t30[30 +: W_W];
	assign w_rnd = w_d + (w_d[W_W-1] ? DN_MASK : '0);
	assign w_dn  = w_rnd >>> DN;
	assign w_sc  = SC_W'(w_dn) <<< UP;

	always_comb begin
		if (w_sc > SMAX_EXT)
			res_sample = SMAX_EXT[SAMPLE_WIDTH-1:0];
		else if (w_sc < SMIN_EXT)
			res_sample = SMIN_EXT[SAMPLE_WIDTH-1:0];
		else
			res_sample = w_sc[SAMPLE_WIDTH-1:0];
	end

	assign res_last = ({1'b0, idx_q} + (IW+1)'(1)) >= {1'b0, len_eff};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ansyn_pkg::ST_IDLE: begin
				if (accept)
					state_d = zero_d ? ansyn_pkg::ST_OUT : ansyn_pkg::ST_PO;
			end
			ansyn_pkg::ST_PO:    state_d = ansyn_pkg::ST_PE;
			ansyn_pkg::ST_PE:    state_d = ansyn_pkg::ST_NO;
			ansyn_pkg::ST_NO:    state_d = ansyn_pkg::ST_NE;
			ansyn_pkg::ST_NE:    state_d = ansyn_pkg::ST_FUND;
			ansyn_pkg::ST_FUND: begin
				state_d = (cnt_q > CNT_W'(1)) ? ansyn_pkg::ST_HA : ansyn_pkg::ST_ENV;
			end
			ansyn_pkg::ST_HA:    state_d = ansyn_pkg::ST_HB;
			ansyn_pkg::ST_HB: begin
				state_d = (i_inc < cnt_q) ? ansyn_pkg::ST_HA : ansyn_pkg::ST_ENV;
			end
			ansyn_pkg::ST_ENV:   state_d = ansyn_pkg::ST_MENV;
			ansyn_pkg::ST_MENV:  state_d = ansyn_pkg::ST_TRUNC;
			ansyn_pkg::ST_TRUNC: state_d = ansyn_pkg::ST_MGAIN;
			ansyn_pkg::ST_MGAIN: state_d = ansyn_pkg::ST_OUT;
			ansyn_pkg::ST_OUT: begin
				if (slot_free)
					state_d = ansyn_pkg::ST_IDLE;
			end
			default: state_d = ansyn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		tick.ready = 1'b0;
		mul_en     = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		out_load   = 1'b0;
		case (state_q)
			ansyn_pkg::ST_IDLE: tick.ready = 1'b1;
			ansyn_pkg::ST_PO: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(fgap);
				mul_b  = MB_W'(bal_inv);
			end
			ansyn_pkg::ST_PE: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(fgap);
				mul_b  = MB_W'(bal_sat);
			end
			ansyn_pkg::ST_NO: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(po_q);
				mul_b  = MB_W'(cnt_q);
			end
			ansyn_pkg::ST_NE: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(pe_q);
				mul_b  = MB_W'(cnt_q);
			end
			ansyn_pkg::ST_FUND: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(fg_sat);
				mul_b  = MB_W'(rom_q);
			end
			ansyn_pkg::ST_HA: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(m_val);
				mul_b  = MB_W'(RECIP_TAB[cnt_q]);
			end
			ansyn_pkg::ST_HB: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(prod_q[RK +: 16]);
				mul_b  = MB_W'(rom_q);
			end
			ansyn_pkg::ST_MENV: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(acc_q);
				mul_b  = MB_W'(env_q);
			end
			ansyn_pkg::ST_MGAIN: begin
				mul_en = 1'b1;
				mul_a  = MA_W'(v_q);
				mul_b  = MB_W'(og_sat);
			end
			ansyn_pkg::ST_OUT: out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ansyn_pkg::ST_IDLE;
			fg_q        <= ansyn_pkg::FUND_GAIN_RST;
			bal_q       <= ansyn_pkg::BALANCE_RST;
			hc_q        <= ansyn_pkg::COUNT_RST;
			og_q        <= ansyn_pkg::OUT_GAIN_RST;
			alen_q      <= ansyn_pkg::ATTACK_LEN_RST;
			nlen_q      <= ansyn_pkg::NOTE_LEN_RST;
			astep_q     <= ansyn_pkg::ATTACK_STEP_RST;
			dstep_q     <= ansyn_pkg::DECAY_STEP_RST;
			idx_q       <= '0;
			env_q       <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			act_q       <= 1'b0;
			cnt_q       <= CNT_W'(1);
			i_q         <= CNT_W'(1);
			zero_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (ansyn_pkg::reg_idx_t'(cfg_idx))
					ansyn_pkg::REG_FUND_GAIN:   fg_q    <= cfg_data[GW-1:0];
					ansyn_pkg::REG_BALANCE:     bal_q   <= cfg_data[GW-1:0];
					ansyn_pkg::REG_COUNT:       hc_q    <= cfg_data[ansyn_pkg::COUNT_W-1:0];
					ansyn_pkg::REG_OUT_GAIN:    og_q    <= cfg_data[GW-1:0];
					ansyn_pkg::REG_ATTACK_LEN:  alen_q  <= cfg_data[IW-1:0];
					ansyn_pkg::REG_NOTE_LEN:    nlen_q  <= cfg_data[IW-1:0];
					ansyn_pkg::REG_ATTACK_STEP: astep_q <= cfg_data[EW-1:0];
					ansyn_pkg::REG_DECAY_STEP:  dstep_q <= cfg_data[EW-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ansyn_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q  <= cnt_d;
						i_q    <= CNT_W'(1);
						zero_q <= zero_d;
						if (tick.start_req) begin
							step_q  <= tick.phase_step;
							idx_q   <= '0;
							env_q   <= '0;
							phase_q <= '0;
							act_q   <= 1'b1;
						end
					end
				end
				ansyn_pkg::ST_HB:  i_q <= i_inc;
				ansyn_pkg::ST_ENV: env_q <= env_next;
				ansyn_pkg::ST_OUT: begin
					if (out_load && !zero_q) begin
						idx_q   <= idx_q + IW'(1);
						phase_q <= phase_q + step_q;
						if (res_last)
							act_q <= 1'b0;
					end
				end
				default: ;
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (audio.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[hph_q[PW-1 -: SINE_AW]];
		if (mul_en)
			prod_q <= prod_d;
		case (state_q)
			ansyn_pkg::ST_IDLE: begin
				if (accept) begin
					acc_q <= '0;
					hph_q <= tick.start_req ? '0 : phase_q;
				end
			end
			ansyn_pkg::ST_PE:    po_q    <= prod_q[30:0];
			ansyn_pkg::ST_NO:    pe_q    <= prod_q[30:0];
			ansyn_pkg::ST_NE:    nodd_q  <= prod_q[N_W-1:0];
			ansyn_pkg::ST_FUND:  neven_q <= prod_q[N_W-1:0];
			ansyn_pkg::ST_HA: begin
				acc_q   <= acc_add;
				nodd_q  <= nodd_dec;
				neven_q <= neven_dec;
			end
			ansyn_pkg::ST_HB:    hph_q <= hph_q + phase_q;
			ansyn_pkg::ST_ENV:   acc_q <= acc_add;
			ansyn_pkg::ST_TRUNC: v_q   <= v_d;
			ansyn_pkg::ST_OUT: begin
				if (out_load) begin
					sample_q <= zero_q ? '0 : res_sample;
					active_q <= !zero_q;
					last_q   <= !zero_q && res_last;
				end
			end
			default: ;
		endcase
	end

	assign audio.valid  = out_valid_q;
	assign audio.sample = sample_q;
	assign audio.active = active_q;
	assign audio.last   = last_q;

	a_emit_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(audio.valid) |-> $past(state_q == ansyn_pkg::ST_OUT))
		else $error("sample request raised outside the output step");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(audio.valid && !audio.active) |-> (audio.sample == '0 && !audio.last))
		else $error("idle tick produced a nonzero sample or last flag");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !zero_q && res_last) |=> !act_q)
		else $error("note still active after its final sample");

	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ansyn_pkg::ST_HA || state_q == ansyn_pkg::ST_HB)
			|-> (i_q < cnt_q && i_q != '0))
		else $error("harmonic index outside 1 .. count-1");

endmodule
`default_nettype wire

>>> tb/sv/additive_note_synth_core_test.sv
// Self-checking bench for additive_note_synth_core: random-paced tick and sample channels,
// config phases written while idle, and an in-bench voice predictor checked per sample.
// Depends on ansyn_pkg, ansyn_tick_if, ansyn_smp_if and additive_note_synth_core.
module additive_note_synth_core_test;

	localparam int     CYCLE_LIMIT  = 2000000;
	localparam int     RANDOM_NOTES = 12;
	localparam int     PHASE_QUOTA  = 140;
	localparam int     UNITY_Q15    = 32768;
	localparam longint Q30_UNIT     = 64'sd1073741824;
	localparam longint ENV_UNIT     = 64'sd16777216;
	localparam longint POLY_1       = 64'sd1686629713;
	localparam longint POLY_3       = -64'sd693598669;
	localparam longint POLY_5       = 64'sd85569304;
	localparam longint POLY_7       = -64'sd5026995;
	localparam longint POLY_9       = 64'sd172271;

	typedef struct packed {
		bit        start;
		bit [31:0] step;
	} tick_req_t;

	typedef struct packed {
		bit signed [15:0] sample;
		bit               active;
		bit               last;
	} voice_out_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [ansyn_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ansyn_pkg::CFG_W-1:0]     cfg_data;

	ansyn_tick_if tick_ch();
	ansyn_smp_if  audio_ch();

	additive_note_synth_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.tick    (tick_ch),
		.audio   (audio_ch)
	);

	tick_req_t  tick_queue[$];
	voice_out_t expected_voice[$];
	shortint    sine_rom[1024];

	bit [15:0] fund_gain_reg, balance_reg, out_gain_reg;
	bit [5:0]  harm_count_reg;
	bit [23:0] attack_len_reg, note_len_reg;
	bit [24:0] attack_step_reg, decay_step_reg;

	bit [23:0] voice_idx;
	bit [24:0] voice_env;
	bit [31:0] voice_phase;
	bit [31:0] voice_step;
	bit        voice_on;

	int failures;
	int cycles;
	int gap_left, tx_quiet, stall_left, rx_quiet;

	always #5 clk = ~clk;

	function automatic longint q30_mul(longint a, longint b);
		return (a * b) / Q30_UNIT;
	endfunction

	function automatic shortint sine_value(int k);
		longint ang, x, x2, p, y, v;
		ang = longint'(k) << 22;
		x = ang & 64'sh3FFF_FFFF;
		if (ang[30])
			x = Q30_UNIT - x;
		x2 = q30_mul(x, x);
		p = POLY_9;
		p = POLY_7 + q30_mul(p, x2);
		p = POLY_5 + q30_mul(p, x2);
		p = POLY_3 + q30_mul(p, x2);
		p = POLY_1 + q30_mul(p, x2);
		y = q30_mul(p, x);
		if (y < 0)
			y = 0;
		v = (y * 32767 + Q30_UNIT / 2) / Q30_UNIT;
		if (v > 32767)
			v = 32767;
		return shortint'(ang[31] ? -v : v);
	endfunction

	function automatic bit [15:0] clamp_q15(bit [15:0] x);
		return (x > 16'd32768) ? 16'd32768 : x;
	endfunction

	function automatic voice_out_t synth_tick(bit start, bit [31:0] step);
		voice_out_t res;
		bit [15:0]   fg, bal, gain;
		int unsigned count, len;
		longint      acc, v, share, g;
		bit [31:0]   hphase;
		bit [25:0]   env_sum;
		bit          closing;
		fg = clamp_q15(fund_gain_reg);
		bal = clamp_q15(balance_reg);
		gain = clamp_q15(out_gain_reg);
		count = 32'(harm_count_reg);
		len = (note_len_reg == 0) ? 32'd1 : 32'(note_len_reg);
		res = '0;
		if (start) begin
			voice_step = step;
			voice_idx = '0;
			voice_env = '0;
			voice_phase = '0;
			voice_on = 1'b1;
		end
		if (!voice_on)
			return res;
		if (count == 0)
			count = 1;
		if (count > 32)
			count = 32;
		acc = longint'(fg) * sine_rom[voice_phase[31:22]];
		for (int i = 1; i < count; i++) begin
			share = (i % 2) ? longint'(UNITY_Q15 - bal) : longint'(bal);
			g = (longint'(count - i) * longint'(UNITY_Q15 - fg) * share) /
				(longint'(2 * count) * 64'sd32768);
			hphase = voice_phase * i;
			acc += g * sine_rom[hphase[31:22]];
		end
		if (voice_idx < attack_len_reg) begin
			env_sum = 26'(voice_env) + 26'(attack_step_reg);
			voice_env = (env_sum > 26'h1FF_FFFF) ? 25'h1FF_FFFF : env_sum[24:0];
		end else begin
			voice_env = (voice_env > decay_step_reg) ? voice_env - decay_step_reg : '0;
		end
		v = (acc * longint'(voice_env)) / ENV_UNIT;
		v = (v * longint'(gain)) / Q30_UNIT;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		closing = (32'(voice_idx) + 32'd1 >= len);
		res.sample = 16'(v);
		res.active = 1'b1;
		res.last = closing;
		voice_phase += voice_step;
		voice_idx += 24'd1;
		if (closing)
			voice_on = 1'b0;
		return res;
	endfunction

	function automatic int pick_pause(inout int quiet_left);
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 2) begin
			quiet_left = $urandom_range(100, 20);
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic bit [15:0] pick_gain();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'($urandom_range(65535, 32769));
			default: return 16'($urandom_range(32768, 0));
		endcase
	endfunction

	function automatic bit [24:0] pick_env_step();
		case ($urandom_range(7))
			0: return 25'd0;
			1: return 25'd16777216;
			2: return 25'h1FF_FFFF;
			3: return 25'($urandom_range(4096, 1));
			default: return 25'($urandom_range(16777216, 0));
		endcase
	endfunction

	function automatic bit [31:0] pick_step();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(65536, 1));
			3: return 32'd1 << $urandom_range(31, 0);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_tick(bit start, bit [31:0] step);
		tick_req_t req;
		req.start = start;
		req.step = step;
		tick_queue = {tick_queue, req};
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_queue.size() != 0 || tick_ch.valid || expected_voice.size() != 0);
	endtask

	task automatic write_reg(ansyn_pkg::reg_idx_t idx, bit [24:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		case (idx)
			ansyn_pkg::REG_FUND_GAIN:   fund_gain_reg = value[15:0];
			ansyn_pkg::REG_BALANCE:     balance_reg = value[15:0];
			ansyn_pkg::REG_COUNT:       harm_count_reg = value[5:0];
			ansyn_pkg::REG_OUT_GAIN:    out_gain_reg = value[15:0];
			ansyn_pkg::REG_ATTACK_LEN:  attack_len_reg = value[23:0];
			ansyn_pkg::REG_NOTE_LEN:    note_len_reg = value[23:0];
			ansyn_pkg::REG_ATTACK_STEP: attack_step_reg = value;
			ansyn_pkg::REG_DECAY_STEP:  decay_step_reg = value;
			default: ;
		endcase
	endtask

	task automatic configure(bit [15:0] fg, bit [15:0] bal, bit [5:0] cnt, bit [15:0] gain,
			bit [23:0] alen, bit [23:0] nlen, bit [24:0] astep, bit [24:0] dstep);
		wait_drained();
		write_reg(ansyn_pkg::REG_FUND_GAIN, 25'(fg));
		write_reg(ansyn_pkg::REG_BALANCE, 25'(bal));
		write_reg(ansyn_pkg::REG_COUNT, 25'(cnt));
		write_reg(ansyn_pkg::REG_OUT_GAIN, 25'(gain));
		write_reg(ansyn_pkg::REG_ATTACK_LEN, 25'(alen));
		write_reg(ansyn_pkg::REG_NOTE_LEN, 25'(nlen));
		write_reg(ansyn_pkg::REG_ATTACK_STEP, astep);
		write_reg(ansyn_pkg::REG_DECAY_STEP, dstep);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic play_random_notes(int quota);
		int        made, n, r, extra;
		bit [5:0]  cnt;
		bit [23:0] alen, nlen;
		made = 0;
		r = $urandom_range(9);
		cnt = (r < 6) ? 6'($urandom_range(8, 1)) : (r < 8) ? 6'($urandom_range(32, 9)) :
			(r == 8) ? 6'($urandom_range(1) ? 0 : 32) : 6'($urandom_range(63, 33));
		r = $urandom_range(9);
		alen = (r < 7) ? 24'($urandom_range(24, 0)) : (r == 7) ? 24'hFF_FFFF : 24'($urandom);
		r = $urandom_range(9);
		nlen = (r < 7) ? 24'($urandom_range(40, 1)) : (r == 7) ? 24'd0 :
			(r == 8) ? 24'hFF_FFFF : 24'($urandom);
		configure(pick_gain(), pick_gain(), cnt, pick_gain(), alen, nlen,
			pick_env_step(), pick_env_step());
		while (made < quota) begin
			r = $urandom_range(9);
			if (r < 7) begin
				n = (note_len_reg == 0) ? 1 : (note_len_reg > 60) ? 60 : int'(note_len_reg);
				if (r == 6)
					n = $urandom_range(n, 1);
				extra = $urandom_range(2, 0);
				push_tick(1'b1, pick_step());
				for (int k = 1; k < n + extra; k++)
					push_tick(1'b0, $urandom);
				made += n + extra;
			end else begin
				n = $urandom_range(4, 1);
				for (int k = 0; k < n; k++)
					push_tick($urandom_range(3) == 0, pick_step());
				made += n;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : tick_driver
		tick_req_t req;
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			tick_ch.start_req <= 1'b0;
			tick_ch.phase_step <= '0;
			gap_left = 0;
		end else if (!tick_ch.valid || tick_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				tick_ch.valid <= 1'b0;
			end else if (tick_queue.size() > 0) begin
				req = tick_queue.pop_front();
				tick_ch.valid <= 1'b1;
				tick_ch.start_req <= req.start;
				tick_ch.phase_step <= req.step;
				gap_left = pick_pause(tx_quiet);
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			audio_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			audio_ch.ready <= 1'b1;
			stall_left = pick_pause(rx_quiet);
		end
	end

	always @(posedge clk) begin : voice_monitor
		voice_out_t want;
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready)
				expected_voice = {expected_voice,
					synth_tick(tick_ch.start_req, tick_ch.phase_step)};
			if (audio_ch.valid && audio_ch.ready) begin
				if (expected_voice.size() == 0) begin
					$display("%0t: unexpected sample request, expected none, got %0d",
						$time, audio_ch.sample);
					failures++;
				end else begin
					want = expected_voice.pop_front();
					if (audio_ch.sample !== want.sample) begin
						$display("%0t: sample mismatch, expected %0d, got %0d",
							$time, want.sample, audio_ch.sample);
						failures++;
					end
					if (audio_ch.active !== want.active) begin
						$display("%0t: active mismatch, expected %0b, got %0b",
							$time, want.active, audio_ch.active);
						failures++;
					end
					if (audio_ch.last !== want.last) begin
						$display("%0t: last mismatch, expected %0b, got %0b",
							$time, want.last, audio_ch.last);
						failures++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		fund_gain_reg = ansyn_pkg::FUND_GAIN_RST;
		balance_reg = ansyn_pkg::BALANCE_RST;
		harm_count_reg = ansyn_pkg::COUNT_RST;
		out_gain_reg = ansyn_pkg::OUT_GAIN_RST;
		attack_len_reg = ansyn_pkg::ATTACK_LEN_RST;
		note_len_reg = ansyn_pkg::NOTE_LEN_RST;
		attack_step_reg = ansyn_pkg::ATTACK_STEP_RST;
		decay_step_reg = ansyn_pkg::DECAY_STEP_RST;
		for (int k = 0; k < 1024; k++)
			sine_rom[k] = sine_value(k);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle ticks, then a one-sample note at reset settings
		push_tick(1'b0, 32'd0);
		push_tick(1'b0, 32'hFFFF_FFFF);
		push_tick(1'b1, 32'd0);
		push_tick(1'b0, 32'h5555_5555);

		// saturating attack, linear decay, restart in mid note
		configure(16'd32768, 16'd16384, 6'd1, 16'd32768, 24'd3, 24'd6,
			25'd16777216, 25'd4194304);
		push_tick(1'b1, 32'h0400_0000);
		push_tick(1'b0, 32'h0);
		push_tick(1'b0, 32'hFFFF_FFFF);
		push_tick(1'b1, 32'hFFFF_FFFF);
		for (int k = 0; k < 5; k++)
			push_tick(1'b0, $urandom);
		push_tick(1'b0, 32'd0);

		// count and gain above range, zero note length, full-scale attack step
		configure(16'd0, 16'd0, 6'd63, 16'hFFFF, 24'hFF_FFFF, 24'd0,
			25'h1FF_FFFF, 25'd16777216);
		push_tick(1'b1, 32'h0100_0000);
		push_tick(1'b1, 32'hAAAA_AAAA);
		push_tick(1'b0, 32'h1357_9BDF);
		push_tick(1'b1, 32'h8000_0000);

		// zero count, envelope decays past zero
		configure(16'hFFFF, 16'hFFFF, 6'd0, 16'd12345, 24'd2, 24'hFF_FFFF,
			25'd8388608, 25'd16777216);
		push_tick(1'b1, 32'h1234_5678);
		for (int k = 0; k < 5; k++)
			push_tick(1'b0, $urandom);

		for (int p = 0; p < RANDOM_NOTES; p++)
			play_random_notes(PHASE_QUOTA);

		wait_drained();
		repeat (80) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
design/ansyn_pkg.sv
design/ansyn_tick_if.sv
design/ansyn_smp_if.sv
design/additive_note_synth_core.sv
tb/sv/additive_note_synth_core_test.sv
